// ----- hdl/cps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants for the circle pair separation unit
// Stage map, path select codes, sideband records and the saturating finish.
// ----------------------------------------------------------------------------
package cps_pkg;

	// pipeline layout
	localparam int FRONT_STAGES = 3;
	localparam int SQRT_STAGES  = 25;
	localparam int POST_STAGES  = 5;
	localparam int DIV_STAGES   = 18;
	localparam int SQRT_BASE    = FRONT_STAGES;
	localparam int POST_BASE    = SQRT_BASE + SQRT_STAGES;
	localparam int DIV_BASE     = POST_BASE + POST_STAGES;
	localparam int LAST_STAGE   = DIV_BASE + DIV_STAGES;
	localparam int NUM_STAGES   = LAST_STAGE + 1;

	localparam logic [15:0] COEF_RESET  = 16'd256;
	localparam logic [15:0] SPEED_RESET = 16'd2560;

	// centres closer than 0.0001 px^2 count as coincident
	localparam logic [51:0] COIN_LIMIT = 52'd6;

	localparam logic [0:0] REG_COEF  = 1'b0;
	localparam logic [0:0] REG_SPEED = 1'b1;

	// which push an item takes
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_RAND = 2'd1;
	localparam logic [1:0] SEL_NORM = 2'd2;

	// carried with the radicand through the square root
	typedef struct packed {
		logic [1:0]         sel;
		logic               neg_x;
		logic               neg_y;
		logic [16:0]        dmx;
		logic [16:0]        dmy;
		logic [16:0]        r;
		logic signed [16:0] rpx;
		logic signed [16:0] rpy;
	} sb_t;

	// carried through the divide
	typedef struct packed {
		logic [1:0]         sel;
		logic               neg_x;
		logic               neg_y;
		logic signed [16:0] rpx;
		logic signed [16:0] rpy;
	} tail_t;

	// clamp a magnitude to the limit and put the sign back
	function automatic logic signed [16:0] sat_sign(input logic neg, input logic [17:0] m,
		input logic [15:0] lim);
		logic [17:0] c;
		c = (m > {2'b00, lim}) ? {2'b00, lim} : m;
		sat_sign = neg ? $signed(-c[16:0]) : $signed(c[16:0]);
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_front: differences, squares, overlap test and random push
// Three stages: subtract, square, sum and compare.
// ----------------------------------------------------------------------------
module cps_front (
	input  wire logic                                clk,
	input  wire logic [cps_pkg::FRONT_STAGES-1:0]    en,
	input  wire logic [15:0]                         max_speed,
	input  wire logic signed [23:0]                  first_x,
	input  wire logic signed [23:0]                  first_y,
	input  wire logic [15:0]                         first_radius,
	input  wire logic signed [23:0]                  second_x,
	input  wire logic signed [23:0]                  second_y,
	input  wire logic [15:0]                         second_radius,
	input  wire logic                                same_object,
	input  wire logic signed [15:0]                  rand_cos,
	input  wire logic signed [15:0]                  rand_sin,
	output logic [33:0]                              rad,
	output cps_pkg::sb_t                             sb
);
	import cps_pkg::*;

	logic signed [24:0] dx_s1, dy_s1;
	logic [16:0]        r_s1;
	logic               same_s1;
	logic signed [32:0] prx_s1, pry_s1;

	logic [24:0] mx;
	logic [24:0] ay;
	logic [25:0] my;
	logic [32:0] apx, apy;
	logic [32:0] rsx, rsy;

	logic [49:0]        mx2_s2;
	logic [51:0]        my2_s2;
	logic [33:0]        rr_s2;
	logic               same_s2;
	sb_t                sb_s2;

	logic [51:0] mag2;
	logic [1:0]  sel;
	sb_t         sb_n;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1   <= $signed({first_x[23], first_x}) - $signed({second_x[23], second_x});
			dy_s1   <= $signed({first_y[23], first_y}) - $signed({second_y[23], second_y});
			r_s1    <= {1'b0, first_radius} + {1'b0, second_radius};
			same_s1 <= same_object;
			prx_s1  <= rand_cos * $signed({1'b0, max_speed});
			pry_s1  <= rand_sin * $signed({1'b0, max_speed});
		end
	end

	always_comb begin
		mx  = dx_s1[24] ? 25'(-dx_s1) : 25'(dx_s1);
		ay  = dy_s1[24] ? 25'(-dy_s1) : 25'(dy_s1);
		my  = {ay, 1'b0};
		apx = prx_s1[32] ? 33'(-prx_s1) : 33'(prx_s1);
		apy = pry_s1[32] ? 33'(-pry_s1) : 33'(pry_s1);
		rsx = apx + 33'd8192;
		rsy = apy + 33'd8192;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mx2_s2    <= mx * mx;
			my2_s2    <= my * my;
			rr_s2     <= r_s1 * r_s1;
			same_s2   <= same_s1;
			sb_s2.sel <= SEL_ZERO;
			sb_s2.neg_x <= dx_s1[24];
			sb_s2.neg_y <= dy_s1[24];
			sb_s2.dmx <= mx[16:0];
			sb_s2.dmy <= my[16:0];
			sb_s2.r   <= r_s1;
			sb_s2.rpx <= sat_sign(prx_s1[32], rsx[31:14], max_speed);
			sb_s2.rpy <= sat_sign(pry_s1[32], rsy[31:14], max_speed);
		end
	end

	always_comb begin
		mag2 = {2'b00, mx2_s2} + my2_s2;
		priority if (mag2 >= {18'd0, rr_s2}) begin
			sel = SEL_ZERO;
		end else if (mag2 <= COIN_LIMIT) begin
			sel = same_s2 ? SEL_ZERO : SEL_RAND;
		end else begin
			sel = SEL_NORM;
		end
		sb_n     = sb_s2;
		sb_n.sel = sel;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			rad <= mag2[33:0];
			sb  <= sb_n;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cps_sqrt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_sqrt: pipelined integer square root
// floor(sqrt(rad << 16)), one root bit per stage, sideband delayed alongside.
// ----------------------------------------------------------------------------
module cps_sqrt (
	input  wire logic                               clk,
	input  wire logic [cps_pkg::SQRT_STAGES-1:0]    en,
	input  wire logic [33:0]                        rad,
	input  wire cps_pkg::sb_t                       sb_in,
	output logic [24:0]                             mag,
	output cps_pkg::sb_t                            sb_out
);
	import cps_pkg::*;

	logic [26:0] rem_s [SQRT_STAGES];
	logic [24:0] q_s   [SQRT_STAGES];
	logic [49:0] n_s   [SQRT_STAGES];
	sb_t         sb_s  [SQRT_STAGES];

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		logic [26:0] rp;
		logic [24:0] qp;
		logic [49:0] np;
		sb_t         sp;
		logic [26:0] sh, t;
		logic        ge;

		if (j == 0) begin : g_first
			assign rp = '0;
			assign qp = '0;
			assign np = {rad, 16'd0};
			assign sp = sb_in;
		end else begin : g_next
			assign rp = rem_s[j-1];
			assign qp = q_s[j-1];
			assign np = n_s[j-1];
			assign sp = sb_s[j-1];
		end

		assign sh = {rp[24:0], np[49:48]};
		assign t  = {qp, 2'b01};
		assign ge = (sh >= t);

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j] <= ge ? (sh - t) : sh;
				q_s[j]   <= {qp[23:0], ge};
				n_s[j]   <= {np[47:0], 2'b00};
				sb_s[j]  <= sp;
			end
		end
	end

	assign mag    = q_s[SQRT_STAGES-1];
	assign sb_out = sb_s[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/cps_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cps_div: pipelined restoring divider
// 17-bit quotient of num / den, overflow flag, one bit per stage after setup.
// ----------------------------------------------------------------------------
module cps_div (
	input  wire logic                              clk,
	input  wire logic [cps_pkg::DIV_STAGES-1:0]    en,
	input  wire logic [58:0]                       num,
	input  wire logic [32:0]                       den,
	output logic [16:0]                            quo,
	output logic                                   ovf
);
	import cps_pkg::*;

	localparam int QB = DIV_STAGES - 1;

	logic [32:0] rem_s [DIV_STAGES];
	logic [16:0] low_s [DIV_STAGES];
	logic [16:0] q_s   [DIV_STAGES];
	logic [32:0] den_s [DIV_STAGES];
	logic        ovf_s [DIV_STAGES];

	// setup: quotient overflows 17 bits when the top part already reaches den
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_s[0] <= (num[58:17] >= {9'd0, den});
			rem_s[0] <= num[49:17];
			low_s[0] <= num[16:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
		end
	end

	for (genvar i = 1; i < DIV_STAGES; i++) begin : g_stage
		logic [33:0] sh;
		logic        ge;
		logic [33:0] diff;

		assign sh   = {rem_s[i-1], low_s[i-1][QB-1]};
		assign ge   = (sh >= {1'b0, den_s[i-1]});
		assign diff = sh - {1'b0, den_s[i-1]};

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= ge ? diff[32:0] : sh[32:0];
				low_s[i] <= {low_s[i-1][QB-2:0], 1'b0};
				q_s[i]   <= {q_s[i-1][QB-2:0], ge};
				den_s[i] <= den_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign quo = q_s[DIV_STAGES-1];
	assign ovf = ovf_s[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- hdl/circle_pair_separation_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circle_pair_separation_unit: separation push for one pair of circles
// Overlap test, square root of the distance, gain and divide, saturation.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  first_*, second_*, same_object, rand_*
// out       output     out_valid/ out_stall push_x, push_y, hit
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One pair per cycle sustained while out_stall is low. Stages: 3 front,
// 25 square root (one root bit each), 5 gain/product, 18 divider (a setup
// stage, then one quotient bit each) and the output register.
// Each stage holds while it is full and the stage after it holds, so bubbles
// close up under a stall and a waiting result blocks new transfers only once
// every stage is full.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module circle_pair_separation_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] first_x,
	input  wire logic signed [23:0] first_y,
	input  wire logic [15:0]        first_radius,
	input  wire logic signed [23:0] second_x,
	input  wire logic signed [23:0] second_y,
	input  wire logic [15:0]        second_radius,
	input  wire logic               same_object,
	input  wire logic signed [15:0] rand_cos,
	input  wire logic signed [15:0] rand_sin,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [16:0]      push_x,
	output logic signed [16:0]      push_y,
	output logic                    hit
);
	import cps_pkg::*;

	logic [15:0] coef_q, speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= COEF_RESET;
			speed_q <= SPEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF:  coef_q  <= cfg_data;
				REG_SPEED: speed_q <= cfg_data;
				default:   coef_q  <= coef_q;
			endcase
		end
	end

	// stage valid bits and advance chain
	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES:0]   rdy;
	logic [NUM_STAGES-1:0] en;

	assign rdy[NUM_STAGES] = !out_stall;
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ctl
		assign rdy[k] = !v_q[k] | rdy[k+1];
		assign en[k]  = rdy[k];
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_q[k] <= 1'b0;
				else if (en[k]) v_q[k] <= in_valid;
			end
		end else begin : g_body
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) v_q[k] <= 1'b0;
				else if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[LAST_STAGE];

	logic [33:0] rad;
	sb_t         sb_f, sb_r;
	logic [24:0] mag;

	cps_front u_front (
		.clk           (clk),
		.en            (en[FRONT_STAGES-1:0]),
		.max_speed     (speed_q),
		.first_x       (first_x),
		.first_y       (first_y),
		.first_radius  (first_radius),
		.second_x      (second_x),
		.second_y      (second_y),
		.second_radius (second_radius),
		.same_object   (same_object),
		.rand_cos      (rand_cos),
		.rand_sin      (rand_sin),
		.rad           (rad),
		.sb            (sb_f)
	);

	cps_sqrt u_sqrt (
		.clk    (clk),
		.en     (en[POST_BASE-1:SQRT_BASE]),
		.rad    (rad),
		.sb_in  (sb_f),
		.mag    (mag),
		.sb_out (sb_r)
	);

	tail_t       tl_in;
	assign tl_in = '{sel: sb_r.sel, neg_x: sb_r.neg_x, neg_y: sb_r.neg_y,
		rpx: sb_r.rpx, rpy: sb_r.rpy};

	// gain and products
	logic [24:0] ovl_p1, mag_p1, mag_p2, mag_p3, mag_p4;
	logic [16:0] dmx_p1, dmy_p1, dmx_p2, dmy_p2;
	logic [40:0] a_p2;
	logic [33:0] phx_p3, phy_p3;
	logic [40:0] plx_p3, ply_p3;
	logic [57:0] numx_p4, numy_p4;
	logic [58:0] n2x_p5, n2y_p5;
	logic [32:0] den_p5;
	tail_t       tl_p1, tl_p2, tl_p3, tl_p4, tl_p5;

	always_ff @(posedge clk) begin
		if (en[POST_BASE]) begin
			ovl_p1 <= {sb_r.r, 8'd0} - mag;
			mag_p1 <= mag;
			dmx_p1 <= sb_r.dmx;
			dmy_p1 <= sb_r.dmy;
			tl_p1  <= tl_in;
		end
		if (en[POST_BASE+1]) begin
			a_p2   <= coef_q * ovl_p1;
			mag_p2 <= mag_p1;
			dmx_p2 <= dmx_p1;
			dmy_p2 <= dmy_p1;
			tl_p2  <= tl_p1;
		end
		if (en[POST_BASE+2]) begin
			phx_p3 <= dmx_p2 * a_p2[40:24];
			plx_p3 <= dmx_p2 * a_p2[23:0];
			phy_p3 <= dmy_p2 * a_p2[40:24];
			ply_p3 <= dmy_p2 * a_p2[23:0];
			mag_p3 <= mag_p2;
			tl_p3  <= tl_p2;
		end
		if (en[POST_BASE+3]) begin
			numx_p4 <= {phx_p3, 24'd0} + {17'd0, plx_p3};
			numy_p4 <= {phy_p3, 24'd0} + {17'd0, ply_p3};
			mag_p4  <= mag_p3;
			tl_p4   <= tl_p3;
		end
		// add half the divisor for round to nearest
		if (en[POST_BASE+4]) begin
			n2x_p5 <= {1'b0, numx_p4} + {27'd0, mag_p4, 7'd0};
			n2y_p5 <= {1'b0, numy_p4} + {27'd0, mag_p4, 7'd0};
			den_p5 <= {mag_p4, 8'd0};
			tl_p5  <= tl_p4;
		end
	end

	logic [16:0] qx, qy;
	logic        ovx, ovy;

	cps_div u_div_x (
		.clk (clk),
		.en  (en[LAST_STAGE-1:DIV_BASE]),
		.num (n2x_p5),
		.den (den_p5),
		.quo (qx),
		.ovf (ovx)
	);

	cps_div u_div_y (
		.clk (clk),
		.en  (en[LAST_STAGE-1:DIV_BASE]),
		.num (n2y_p5),
		.den (den_p5),
		.quo (qy),
		.ovf (ovy)
	);

	tail_t tl_d [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_tail
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en[DIV_BASE]) tl_d[i] <= tl_p5;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[DIV_BASE+i]) tl_d[i] <= tl_d[i-1];
			end
		end
	end

	tail_t              tl_last;
	logic signed [16:0] nx, ny, fx, fy;

	always_comb begin
		tl_last = tl_d[DIV_STAGES-1];
		nx = sat_sign(tl_last.neg_x, ovx ? 18'h3FFFF : {1'b0, qx}, speed_q);
		ny = sat_sign(tl_last.neg_y, ovy ? 18'h3FFFF : {1'b0, qy}, speed_q);
		unique case (tl_last.sel)
			SEL_RAND: begin
				fx = tl_last.rpx;
				fy = tl_last.rpy;
			end
			SEL_NORM: begin
				fx = nx;
				fy = ny;
			end
			default: begin
				fx = '0;
				fy = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[LAST_STAGE]) begin
			push_x <= fx;
			push_y <= fy;
			hit    <= (fx != '0) || (fy != '0);
		end
	end

endmodule
`default_nettype wire

// ----- verif/tb_circle_pair_separation_unit.sv -----
// ----------------------------------------------------------------------------
// tb_circle_pair_separation_unit: self-checking bench for the separation unit
// Predicts each push from the pair and the live register settings and checks
// every output transfer in order. The run covers directed corners, several
// gain and limit settings, random pairs, output back-pressure and drains.
// ----------------------------------------------------------------------------
module tb_circle_pair_separation_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cps_pkg::*;

	localparam int LATENCY   = 52;
	localparam int CYCLE_CAP = 400000;

	typedef struct {
		logic signed [23:0] fx, fy, sx, sy;
		logic [15:0]        fr, sr;
		logic               same;
		logic signed [15:0] rc, rs;
	} pair_t;

	typedef struct {
		logic signed [16:0] px, py;
		logic               h;
	} push_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_COEF;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [23:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [15:0] first_radius = '0, second_radius = '0;
	logic same_object = 1'b0;
	logic signed [15:0] rand_cos = '0, rand_sin = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [16:0] push_x, push_y;
	logic hit;

	circle_pair_separation_unit DUT (.*);

	logic [15:0] gain = COEF_RESET;
	logic [15:0] speed_lim = SPEED_RESET;
	push_t pending_push[$];
	int errors = 0, checked = 0, hits_seen = 0, sent = 0;
	int cycles = 0;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;
	int hold_left = 0;

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic longint unsigned mag_of(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [16:0] clamp_push(input bit neg, input longint unsigned m);
		longint v;
		if (m > speed_lim) m = speed_lim;
		v = neg ? -longint'(m) : longint'(m);
		return v[16:0];
	endfunction

	function automatic logic signed [16:0] scatter_comp(input logic signed [15:0] u);
		longint p;
		p = longint'(u) * longint'(speed_lim);
		return clamp_push(p < 0, (mag_of(p) + 8192) >> 14);
	endfunction

	function automatic push_t predict_push(input pair_t p);
		push_t o;
		longint dx, dy;
		longint unsigned r, mag2, rr, mag, a, den;
		dx = longint'(p.fx) - longint'(p.sx);
		dy = 2 * (longint'(p.fy) - longint'(p.sy));
		r = longint'(p.fr) + longint'(p.sr);
		mag2 = mag_of(dx) * mag_of(dx) + mag_of(dy) * mag_of(dy);
		rr = r * r;
		o.px = '0;
		o.py = '0;
		if (mag2 < rr) begin
			if (mag2 <= 6) begin
				if (!p.same) begin
					o.px = scatter_comp(p.rc);
					o.py = scatter_comp(p.rs);
				end
			end else begin
				mag = root_floor(mag2 << 16);
				a = longint'(gain) * ((r << 8) - mag);
				den = mag << 8;
				o.px = clamp_push(dx < 0, (mag_of(dx) * a + (den >> 1)) / den);
				o.py = clamp_push(dy < 0, (mag_of(dy) * a + (den >> 1)) / den);
			end
		end
		o.h = (o.px != 0 || o.py != 0);
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d", checked, what, got, want);
	endtask

	always @(posedge clk) begin
		push_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_push.size() == 0) begin
				report_mismatch("unexpected transfer, hit", hit, 0);
			end else begin
				e = pending_push.pop_front();
				if (push_x !== e.px) report_mismatch("push_x", push_x, e.px);
				if (push_y !== e.py) report_mismatch("push_y", push_y, e.py);
				if (hit !== e.h) report_mismatch("hit", hit, e.h);
				if (e.h) hits_seen++;
			end
			checked++;
		end
	end

	// receiver stall; a long hold-off is counted here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_on && ($urandom_range(99) < 9);
		end
	end

	task automatic send_pair(input pair_t p);
		if (idle_on && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_x <= p.fx;
		first_y <= p.fy;
		first_radius <= p.fr;
		second_x <= p.sx;
		second_y <= p.sy;
		second_radius <= p.sr;
		same_object <= p.same;
		rand_cos <= p.rc;
		rand_sin <= p.rs;
		do @(posedge clk); while (in_stall);
		pending_push.push_back(predict_push(p));
		sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_push.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] coef, input logic [15:0] lim);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_COEF;
		cfg_data <= coef;
		@(posedge clk);
		gain = coef;
		cfg_index <= REG_SPEED;
		cfg_data <= lim;
		@(posedge clk);
		speed_lim = lim;
		cfg_we <= 1'b0;
	endtask

	function automatic pair_t make_pair(input int fx, fy, sx, sy, fr, sr, same, rc, rs);
		pair_t p;
		p.fx = fx; p.fy = fy; p.sx = sx; p.sy = sy;
		p.fr = fr; p.sr = sr; p.same = same; p.rc = rc; p.rs = rs;
		return p;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int k, rsum, ox, oy;
		k = $urandom_range(99);
		p.fx = $urandom; p.fy = $urandom; p.sx = $urandom; p.sy = $urandom;
		p.same = $urandom_range(1);
		p.rc = $urandom_range(32768) - 16384;
		p.rs = $urandom_range(32768) - 16384;
		if ($urandom_range(9) == 0) begin
			p.rc = $urandom;
			p.rs = $urandom;
		end
		p.fr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4095);
		p.sr = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4095);
		rsum = p.fr + p.sr;
		if (k < 12) begin
			// nearly coincident centres
			p.sx = p.fx - ($urandom_range(4) - 2);
			p.sy = p.fy - ($urandom_range(2) - 1);
		end else if (k < 82) begin
			ox = $urandom_range(2 * rsum) - rsum;
			oy = $urandom_range(rsum) - rsum / 2;
			p.sx = p.fx - ox;
			p.sy = p.fy - oy;
		end
		return p;
	endfunction

	task automatic test_directed();
		send_pair(make_pair(8388607, 8388607, -8388608, -8388608, 65535, 65535, 0, 16384, 16384));
		send_pair(make_pair(-8388608, 0, 8388607, 0, 65535, 65535, 1, 0, 0));
		send_pair(make_pair(0, 0, 0, 0, 65535, 65535, 0, 16384, -16384));
		send_pair(make_pair(0, 0, 0, 0, 65535, 65535, 1, 16384, -16384));
		send_pair(make_pair(5, 5, 5, 5, 0, 0, 0, 16384, 16384));
		send_pair(make_pair(100, 7, 100, 7, 1, 0, 0, -16384, 0));
		send_pair(make_pair(0, 0, 0, 0, 10, 10, 0, 32767, -32768));
		send_pair(make_pair(2, 0, 0, 1, 300, 300, 0, 11585, 11585));
		send_pair(make_pair(2, 1, 0, 0, 300, 300, 1, 11585, 11585));
		send_pair(make_pair(2, 0, 0, 0, 300, 300, 1, 1, 1));
		send_pair(make_pair(200, 0, 0, 0, 100, 100, 0, 0, 0));
		send_pair(make_pair(199, 0, 0, 0, 100, 100, 0, 0, 0));
		send_pair(make_pair(0, 100, 0, 0, 100, 100, 0, 0, 0));
		send_pair(make_pair(0, -99, 0, 0, 100, 100, 0, 0, 0));
		send_pair(make_pair(-3, 0, 0, 0, 65535, 0, 0, 0, 0));
		send_pair(make_pair(1000, -2000, -1000, 2000, 65535, 65535, 0, 0, 0));
		send_pair(make_pair(-1, -1, 0, 0, 1, 2, 0, -1, 1));
	endtask

	task automatic test_settings();
		logic [15:0] c[6] = '{16'd0, 16'd256, 16'd65535, 16'd1, 16'd4096, 16'd128};
		logic [15:0] s[6] = '{16'd2560, 16'd0, 16'd65535, 16'd1, 16'd65535, 16'd700};
		for (int i = 0; i < 6; i++) begin
			set_regs(c[i], s[i]);
			test_directed();
			for (int j = 0; j < 20; j++) send_pair(random_pair());
		end
	endtask

	task automatic test_random();
		set_regs(COEF_RESET, SPEED_RESET);
		for (int j = 0; j < 500; j++) send_pair(random_pair());
		set_regs($urandom, $urandom);
		for (int j = 0; j < 300; j++) send_pair(random_pair());
	endtask

	// receiver holds off while pairs keep coming, then no idling at all
	task automatic test_backpressure();
		set_regs(16'd512, 16'd4000);
		hold_req = 1'b1;
		for (int j = 0; j < 120; j++) send_pair(random_pair());
		drain_results();
		idle_on = 1'b0;
		for (int j = 0; j < 150; j++) send_pair(random_pair());
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_random();
		test_backpressure();
		drain_results();
		$display("%0d pairs sent, %0d results checked, %0d with a push", sent, checked,
			hits_seen);
		$display("covered directed corners, six register settings, random pairs and stalls");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
